FILE: hw/rtl/node_registry_with_liveness_defines.svh
// Assertion macros for the node registry block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef NODE_REGISTRY_WITH_LIVENESS_DEFINES_SVH
`define NODE_REGISTRY_WITH_LIVENESS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nrl_pkg.sv
// Shared constants, codes and types of the node registry block.
// No dependencies; imported by every module of the block.
`default_nettype none

package nrl_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Fixed values.
  localparam logic [7:0]  NODE_NONE     = 8'hFF;
  localparam logic [7:0]  NODE_RSVD     = 8'h00;
  localparam logic [31:0] TIMEOUT_RESET = 32'd60000;
  localparam logic [4:0]  OFFLINE_MAX   = 5'h1F;

  // Operation codes.
  localparam logic [1:0] OP_JOIN  = 2'd0;
  localparam logic [1:0] OP_HEARD = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  // Result codes.
  localparam logic [2:0] RC_NEW_ID     = 3'd0;
  localparam logic [2:0] RC_KNOWN_ID   = 3'd1;
  localparam logic [2:0] RC_REG_FULL   = 3'd2;
  localparam logic [2:0] RC_TRACKED    = 3'd3;
  localparam logic [2:0] RC_RESERVED   = 3'd4;
  localparam logic [2:0] RC_NO_SLOT    = 3'd5;
  localparam logic [2:0] RC_SWEEP_DONE = 3'd6;

  // Registry append: device goes to the entry at the current count.
  typedef struct packed {
    logic        en;
    logic [31:0] device;
  } reg_wr_t;

  // Status slot update.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             set_node;
    logic [7:0]       node;
    logic             set_seen;
    logic [31:0]      seen;
    logic             online;
  } stat_wr_t;

  // Contents of one table row at the scan index.
  typedef struct packed {
    logic [31:0] device;
    logic [7:0]  node;
    logic [31:0] last_seen;
    logic        online;
  } entry_rd_t;

  // Shared compare unit results.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/node_registry_with_liveness.sv
// Join scans the registry and, unless full, the status table; heard scans the status table;
// sweep ages every status row; a reserved ID or unused opcode goes straight to the result.
// Scans take one row per cycle via the shared compare unit. One transaction at a time; the
// next is taken once the result sits in the output register. Synchronous active-low
// reset empties the registry, frees every status slot and sets the timeout to 60000.
`default_nettype none

`include "node_registry_with_liveness_defines.svh"

module node_registry_with_liveness (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_device_id,
  input  wire logic [7:0]  in_node_id,
  input  wire logic [31:0] in_now_ms,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_result_code,
  output logic [7:0]       out_assigned_id,
  output logic [4:0]       out_offline_count,
  // Configuration.
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import nrl_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REG      = 3'd1;
  localparam logic [2:0] S_STAT     = 3'd2;
  localparam logic [2:0] S_STAT_END = 3'd3;
  localparam logic [2:0] S_SWEEP    = 3'd4;
  localparam logic [2:0] S_FIN      = 3'd5;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      dev_r, dev_nxt;
  logic [7:0]       node_r, node_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [2:0]       code_r, code_nxt;
  logic [7:0]       assigned_r, assigned_nxt;
  logic [4:0]       offline_r, offline_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [31:0]      timeout_r;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_code_r;
  logic [7:0]       out_assigned_r;
  logic [4:0]       out_offline_r;

  logic             in_take;
  logic             out_load;
  logic [CNT_W-1:0] reg_count;
  logic [7:0]       new_id;
  logic [7:0]       hit_id;
  entry_rd_t        row;
  reg_wr_t          reg_wr;
  stat_wr_t         stat_wr;
  logic [31:0]      cmp_a, cmp_b;
  cmp_res_t         cmp;

  nrl_tables u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r[IDX_W-1:0]),
    .reg_wr    (reg_wr),
    .stat_wr   (stat_wr),
    .rd        (row),
    .reg_count (reg_count)
  );

  // Operand select for the shared compare unit.
  always_comb begin
    case (state_r)
      S_REG: begin
        cmp_a = row.device;
        cmp_b = dev_r;
      end
      S_SWEEP: begin
        cmp_a = now_r;
        cmp_b = row.last_seen;
      end
      default: begin
        cmp_a = {24'd0, row.node};
        cmp_b = {24'd0, node_r};
      end
    endcase
  end

  nrl_cmp u_cmp (
    .op_a  (cmp_a),
    .op_b  (cmp_b),
    .limit (timeout_r),
    .res   (cmp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign new_id   = 8'(reg_count) + 8'd1;
  assign hit_id   = 8'(idx_r) + 8'd1;

  // Sequencer: registry scan, status scan and sweep, one row per cycle.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    dev_nxt      = dev_r;
    node_nxt     = node_r;
    now_nxt      = now_r;
    idx_nxt      = idx_r;
    code_nxt     = code_r;
    assigned_nxt = assigned_r;
    offline_nxt  = offline_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    reg_wr       = '0;
    stat_wr      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt       = in_opcode;
          dev_nxt      = in_device_id;
          node_nxt     = in_node_id;
          now_nxt      = in_now_ms;
          idx_nxt      = '0;
          assigned_nxt = NODE_NONE;
          offline_nxt  = '0;
          free_vld_nxt = 1'b0;
          case (in_opcode)
            OP_JOIN: begin
              state_nxt = S_REG;
            end
            OP_HEARD: begin
              if (in_node_id == NODE_RSVD || in_node_id == NODE_NONE) begin
                code_nxt  = RC_RESERVED;
                state_nxt = S_FIN;
              end else begin
                code_nxt  = RC_TRACKED;
                state_nxt = S_STAT;
              end
            end
            OP_SWEEP: begin
              code_nxt  = RC_SWEEP_DONE;
              state_nxt = S_SWEEP;
            end
            default: begin
              code_nxt  = RC_RESERVED;
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // Look the device up among the filled registry entries; append it if absent and not full.
      S_REG: begin
        if (idx_r == reg_count) begin
          if (reg_count == FULL_CNT) begin
            code_nxt  = RC_REG_FULL;
            state_nxt = S_FIN;
          end else begin
            reg_wr.en     = 1'b1;
            reg_wr.device = dev_r;
            code_nxt      = RC_NEW_ID;
            assigned_nxt  = new_id;
            node_nxt      = new_id;
            idx_nxt       = '0;
            state_nxt     = S_STAT;
          end
        end else if (cmp.eq) begin
          code_nxt     = RC_KNOWN_ID;
          assigned_nxt = hit_id;
          node_nxt     = hit_id;
          idx_nxt      = '0;
          state_nxt    = S_STAT;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      // Find the node's slot, remembering the first free one on the way.
      S_STAT: begin
        if (cmp.eq) begin
          stat_wr.en       = 1'b1;
          stat_wr.addr     = idx_r[IDX_W-1:0];
          stat_wr.set_seen = 1'b1;
          stat_wr.seen     = now_r;
          stat_wr.online   = 1'b1;
          state_nxt        = S_FIN;
        end else begin
          if (row.node == NODE_NONE && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = idx_r[IDX_W-1:0];
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_STAT_END;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      // Not tracked yet: claim the first free slot if there is one.
      S_STAT_END: begin
        if (free_vld_r) begin
          stat_wr.en       = 1'b1;
          stat_wr.addr     = free_idx_r;
          stat_wr.set_node = 1'b1;
          stat_wr.node     = node_r;
          stat_wr.set_seen = 1'b1;
          stat_wr.seen     = now_r;
          stat_wr.online   = 1'b1;
        end else if (op_r == OP_HEARD) begin
          code_nxt = RC_NO_SLOT;
        end
        state_nxt = S_FIN;
      end

      // Age every tracked online node and take the stale ones offline.
      S_SWEEP: begin
        if (row.node != NODE_NONE && row.online && cmp.gt) begin
          stat_wr.en     = 1'b1;
          stat_wr.addr   = idx_r[IDX_W-1:0];
          stat_wr.online = 1'b0;
          if (offline_r != OFFLINE_MAX) begin
            offline_nxt = offline_r + 5'd1;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      // Wait for the output register to be free.
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_vld_r  <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_vld_r  <= free_vld_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    dev_r      <= dev_nxt;
    node_r     <= node_nxt;
    now_r      <= now_nxt;
    idx_r      <= idx_nxt;
    code_r     <= code_nxt;
    assigned_r <= assigned_nxt;
    offline_r  <= offline_nxt;
    free_idx_r <= free_idx_nxt;
  end

  // Output register, loaded when a finished transaction can be presented.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r     <= code_r;
      out_assigned_r <= assigned_r;
      out_offline_r  <= offline_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_code   = out_code_r;
  assign out_assigned_id   = out_assigned_r;
  assign out_offline_count = out_offline_r;

  // Checks on the sequencer and tables.
  `NRL_ASSERT_NOW(a_reg_append_room, reg_wr.en, reg_count < FULL_CNT, "registry append when full")
  `NRL_ASSERT_NEXT(a_take_leaves_idle, in_take, state_r != S_IDLE, "accepted input left block idle")
  `NRL_ASSERT_NEXT(a_fin_holds, (state_r == S_FIN) && out_valid_r && out_stall, (state_r == S_FIN) && out_valid_r, "result overwrote a waiting result")
  `NRL_ASSERT_NOW(a_sweep_count, state_r == S_SWEEP, offline_r <= 5'(TABLE_ENTRIES), "sweep count beyond table size")

endmodule

`default_nettype wire

FILE: hw/rtl/nrl_cmp.sv
// Shared compare unit: equality and wrapping age against a limit.
// Depends on nrl_pkg.
`default_nettype none

module nrl_cmp (
  input  wire logic [31:0]      op_a,
  input  wire logic [31:0]      op_b,
  input  wire logic [31:0]      limit,
  output nrl_pkg::cmp_res_t     res
);
  import nrl_pkg::*;

  logic [31:0] diff;

  // One subtractor serves both the match test and the age test.
  assign diff   = op_a - op_b;
  assign res.eq = (diff == 32'd0);
  assign res.gt = (diff > limit);

endmodule

`default_nettype wire

FILE: hw/rtl/nrl_tables.sv
// Registry and status tables, read at the sequencer's scan index.
// Depends on nrl_pkg.
`default_nettype none

module nrl_tables (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [nrl_pkg::IDX_W-1:0] rd_idx,
  input  wire nrl_pkg::reg_wr_t          reg_wr,
  input  wire nrl_pkg::stat_wr_t         stat_wr,
  output nrl_pkg::entry_rd_t             rd,
  output logic [nrl_pkg::CNT_W-1:0]      reg_count
);
  import nrl_pkg::*;

  logic [31:0]      reg_device_r [TABLE_ENTRIES];
  logic [CNT_W-1:0] reg_count_r;
  logic [7:0]       stat_node_r  [TABLE_ENTRIES];
  logic [31:0]      stat_seen_r  [TABLE_ENTRIES];
  logic             stat_online_r[TABLE_ENTRIES];

  // Registry devices hold no reset; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (reg_wr.en) begin
      reg_device_r[reg_count_r[IDX_W-1:0]] <= reg_wr.device;
    end
  end

  // Registry fill count. Node IDs are handed out in order, so entry i owns ID i+1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_count_r <= '0;
    end else if (reg_wr.en) begin
      reg_count_r <= reg_count_r + CNT_W'(1);
    end
  end

  // Status table: reset marks every slot free and offline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        stat_node_r[i]   <= NODE_NONE;
        stat_seen_r[i]   <= '0;
        stat_online_r[i] <= 1'b0;
      end
    end else if (stat_wr.en) begin
      if (stat_wr.set_node) begin
        stat_node_r[stat_wr.addr] <= stat_wr.node;
      end
      if (stat_wr.set_seen) begin
        stat_seen_r[stat_wr.addr] <= stat_wr.seen;
      end
      stat_online_r[stat_wr.addr] <= stat_wr.online;
    end
  end

  // Row read at the scan index.
  assign rd.device    = reg_device_r[rd_idx];
  assign rd.node      = stat_node_r[rd_idx];
  assign rd.last_seen = stat_seen_r[rd_idx];
  assign rd.online    = stat_online_r[rd_idx];
  assign reg_count    = reg_count_r;

endmodule

`default_nettype wire
